FILE: design/imvm_pkg.sv
`default_nettype none

package imvm_pkg;

    // configuration register widths and indexes
    localparam int CFG_IDX_BITS  = 2;
    localparam int SPM_BITS      = 11;
    localparam int MPB_BITS      = 16;
    localparam int PART_BITS     = 8;
    localparam int TICK_BITS     = 20;
    localparam int CFG_DATA_BITS = 20;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPM  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MPB  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PART = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICK = 2'd3;

    localparam logic [SPM_BITS-1:0]  SPM_RESET  = 11'd16;
    localparam logic [MPB_BITS-1:0]  MPB_RESET  = 16'd16;
    localparam logic [PART_BITS-1:0] PART_RESET = 8'd0;
    localparam logic [TICK_BITS-1:0] TICK_RESET = 20'd1000;

    // payload widths
    localparam int ACTION_BITS = 2;
    localparam int TS_BITS     = 32;
    localparam int KIND_BITS   = 2;
    localparam int MEAN_BITS   = 40;
    localparam int VAR_BITS    = 56;
    localparam int IDX_BITS    = 16;

    // durations and sums
    localparam int MAX_SAMPLES = 1024;
    localparam int DUR_BITS    = 24;
    localparam logic [DUR_BITS-1:0] DUR_CAP = {DUR_BITS{1'b1}};
    localparam int SUM_BITS    = 34;
    localparam int SQ_DUR_BITS = 2 * DUR_BITS;
    localparam int SQ_SUM_BITS = 58;
    localparam int HALF_BITS   = SUM_BITS / 2;
    localparam int PROD_BITS   = SUM_BITS + HALF_BITS;
    localparam int S2_BITS     = 2 * SUM_BITS;
    localparam int NT_BITS     = SPM_BITS + TICK_BITS;
    localparam int NQ_BITS     = SPM_BITS + SQ_SUM_BITS;
    localparam int MEAN_FRAC   = 16;
    localparam int VAR_FRAC    = 8;

    // shared divider geometry
    localparam int DIVIDEND_BITS = NQ_BITS + VAR_FRAC;
    localparam int DIVISOR_BITS  = 2 * NT_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_START_SAMPLE  = 2'd0,
        ACT_START_PARTIAL = 2'd1,
        ACT_END_PARTIAL   = 2'd2,
        ACT_END_SAMPLE    = 2'd3
    } t_action;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_MEAS        = 2'd0,
        KIND_NO_PARTIALS = 2'd1,
        KIND_TOO_MANY    = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PACC,
        ST_SACC,
        ST_SQACC,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIFF,
        ST_DIV,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  in_ready;
        logic  start_sample;
        logic  start_partial;
        logic  close_partial;
        logic  end_sample;
        logic  clear_partials;
        logic  calc_dur;
        logic  acc_partial;
        logic  acc_sample;
        logic  acc_square;
        logic  mul1;
        logic  mul2;
        logic  mul3;
        logic  div_start;
        logic  emit;
        t_kind kind;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic    in_fire;
        t_action act;
        logic    sampling;
        logic    whole;
        logic    part_open;
        logic    part_full;
        logic    no_partials;
        logic    meas_ready;
        logic    div_busy;
        logic    out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: design/imvm_in_if.sv
`default_nettype none

interface imvm_in_if;
    logic                               valid;
    logic                               ready;
    logic [imvm_pkg::ACTION_BITS-1:0]   action;
    logic [imvm_pkg::TS_BITS-1:0]       timestamp;

    modport source (output valid, output action, output timestamp, input ready);
    modport sink   (input valid, input action, input timestamp, output ready);
endinterface

`default_nettype wire

FILE: design/imvm_out_if.sv
`default_nettype none

interface imvm_out_if;
    logic                             valid;
    logic                             ready;
    logic [imvm_pkg::KIND_BITS-1:0]   kind;
    logic [imvm_pkg::MEAN_BITS-1:0]   mean_ms;
    logic [imvm_pkg::VAR_BITS-1:0]    variance_ms2;
    logic [imvm_pkg::IDX_BITS-1:0]    measurement_index;
    logic                             batch_done;

    modport source (output valid, output kind, output mean_ms, output variance_ms2,
                    output measurement_index, output batch_done, input ready);
    modport sink   (input valid, input kind, input mean_ms, input variance_ms2,
                    input measurement_index, input batch_done, output ready);
endinterface

`default_nettype wire

FILE: design/imvm_div.sv
`default_nettype none

module imvm_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [imvm_pkg::DIVIDEND_BITS-1:0]   i_dividend,
    input  logic [imvm_pkg::DIVISOR_BITS-1:0]    i_divisor,
    output logic                                 o_busy,
    output logic [imvm_pkg::DIVIDEND_BITS-1:0]   o_quot
);

    logic                                r_busy;
    logic [imvm_pkg::DIV_CNT_BITS-1:0]   r_cnt;
    logic [imvm_pkg::DIVIDEND_BITS-1:0]  r_quot;
    logic [imvm_pkg::DIVISOR_BITS-1:0]   r_rem;
    logic [imvm_pkg::DIVISOR_BITS-1:0]   r_divisor;

    logic [imvm_pkg::DIVISOR_BITS:0]     trial;
    logic                                n_bit;
    logic [imvm_pkg::DIVISOR_BITS-1:0]   n_rem;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quot[imvm_pkg::DIVIDEND_BITS-1]};
        n_bit = (trial >= {1'b0, r_divisor});
        if (n_bit) begin
            n_rem = imvm_pkg::DIVISOR_BITS'(trial - {1'b0, r_divisor});
        end else begin
            n_rem = imvm_pkg::DIVISOR_BITS'(trial);
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= imvm_pkg::DIV_CNT_BITS'(imvm_pkg::DIVIDEND_BITS - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // dividend shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[imvm_pkg::DIVIDEND_BITS-2:0], n_bit};
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: design/imvm_ctrl.sv
`default_nettype none

module imvm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imvm_pkg::t_status  i_status,
    output imvm_pkg::t_cmd     o_cmd
);

    imvm_pkg::t_state r_state;
    imvm_pkg::t_state n_state;
    imvm_pkg::t_kind  r_kind;
    imvm_pkg::t_kind  n_kind;

    // state and pending result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imvm_pkg::ST_IDLE;
            r_kind  <= imvm_pkg::KIND_MEAS;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        case (r_state)
            imvm_pkg::ST_IDLE: begin
                if (i_status.in_fire) begin
                    n_state = imvm_pkg::ST_EVAL;
                end
            end
            imvm_pkg::ST_EVAL: begin
                n_state = imvm_pkg::ST_IDLE;
                case (i_status.act)
                    imvm_pkg::ACT_END_PARTIAL: begin
                        if (i_status.sampling && !i_status.whole && i_status.part_open) begin
                            if (i_status.part_full) begin
                                n_state = imvm_pkg::ST_EMIT;
                                n_kind  = imvm_pkg::KIND_TOO_MANY;
                            end else begin
                                n_state = imvm_pkg::ST_PACC;
                            end
                        end
                    end
                    imvm_pkg::ACT_END_SAMPLE: begin
                        if (i_status.sampling) begin
                            if (!i_status.whole && i_status.no_partials) begin
                                n_state = imvm_pkg::ST_EMIT;
                                n_kind  = imvm_pkg::KIND_NO_PARTIALS;
                            end else begin
                                n_state = imvm_pkg::ST_SACC;
                            end
                        end
                    end
                    default: begin
                        n_state = imvm_pkg::ST_IDLE;
                    end
                endcase
            end
            imvm_pkg::ST_PACC:  n_state = imvm_pkg::ST_IDLE;
            imvm_pkg::ST_SACC:  n_state = imvm_pkg::ST_SQACC;
            imvm_pkg::ST_SQACC: begin
                n_state = i_status.meas_ready ? imvm_pkg::ST_MUL1 : imvm_pkg::ST_IDLE;
            end
            imvm_pkg::ST_MUL1:  n_state = imvm_pkg::ST_MUL2;
            imvm_pkg::ST_MUL2:  n_state = imvm_pkg::ST_MUL3;
            imvm_pkg::ST_MUL3:  n_state = imvm_pkg::ST_DIFF;
            imvm_pkg::ST_DIFF: begin
                n_state = imvm_pkg::ST_DIV;
                n_kind  = imvm_pkg::KIND_MEAS;
            end
            imvm_pkg::ST_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = imvm_pkg::ST_EMIT;
                end
            end
            imvm_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = imvm_pkg::ST_IDLE;
                end
            end
            default: n_state = imvm_pkg::ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            imvm_pkg::ST_IDLE: o_cmd.in_ready = 1'b1;
            imvm_pkg::ST_EVAL: begin
                case (i_status.act)
                    imvm_pkg::ACT_START_SAMPLE: o_cmd.start_sample = 1'b1;
                    imvm_pkg::ACT_START_PARTIAL: begin
                        o_cmd.start_partial = i_status.sampling && !i_status.whole;
                    end
                    imvm_pkg::ACT_END_PARTIAL: begin
                        if (i_status.sampling && !i_status.whole && i_status.part_open) begin
                            o_cmd.close_partial = 1'b1;
                            o_cmd.calc_dur      = 1'b1;
                        end
                    end
                    imvm_pkg::ACT_END_SAMPLE: begin
                        if (i_status.sampling) begin
                            o_cmd.end_sample     = 1'b1;
                            o_cmd.calc_dur       = 1'b1;
                            o_cmd.clear_partials = !i_status.whole && i_status.no_partials;
                        end
                    end
                    default: o_cmd.start_sample = 1'b0;
                endcase
            end
            imvm_pkg::ST_PACC:  o_cmd.acc_partial = 1'b1;
            imvm_pkg::ST_SACC:  o_cmd.acc_sample  = 1'b1;
            imvm_pkg::ST_SQACC: o_cmd.acc_square  = 1'b1;
            imvm_pkg::ST_MUL1:  o_cmd.mul1        = 1'b1;
            imvm_pkg::ST_MUL2:  o_cmd.mul2        = 1'b1;
            imvm_pkg::ST_MUL3:  o_cmd.mul3        = 1'b1;
            imvm_pkg::ST_DIFF:  o_cmd.div_start   = 1'b1;
            imvm_pkg::ST_EMIT:  o_cmd.emit        = i_status.out_free;
            default:            o_cmd.in_ready    = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/imvm_dp.sv
`default_nettype none

module imvm_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [imvm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [imvm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    imvm_in_if.sink                              i_in,
    imvm_out_if.source                           o_out,
    input  imvm_pkg::t_cmd                       i_cmd,
    output imvm_pkg::t_status                    o_status
);

    // configuration
    logic [imvm_pkg::SPM_BITS-1:0]   r_spm;
    logic [imvm_pkg::MPB_BITS-1:0]   r_mpb;
    logic [imvm_pkg::PART_BITS-1:0]  r_max_part;
    logic [imvm_pkg::TICK_BITS-1:0]  r_tpm;

    // latched event
    imvm_pkg::t_action               r_ev_act;
    logic [imvm_pkg::TS_BITS-1:0]    r_ev_ts;

    // sample state
    logic                            r_sampling;
    logic [imvm_pkg::TS_BITS-1:0]    r_sample_start;
    logic                            r_part_open;
    logic [imvm_pkg::TS_BITS-1:0]    r_part_start;
    logic [imvm_pkg::PART_BITS-1:0]  r_part_count;
    logic [imvm_pkg::DUR_BITS-1:0]   r_part_sum;
    logic [imvm_pkg::DUR_BITS-1:0]   r_dur;

    // measurement accumulators
    logic [imvm_pkg::SPM_BITS-1:0]    r_sample_count;
    logic [imvm_pkg::SUM_BITS-1:0]    r_dur_sum;
    logic [imvm_pkg::SQ_DUR_BITS-1:0] r_sq_dur;
    logic [imvm_pkg::SQ_SUM_BITS-1:0] r_sq_sum;
    logic [imvm_pkg::MPB_BITS-1:0]    r_meas_count;

    // closing arithmetic
    logic [imvm_pkg::NT_BITS-1:0]      r_nt;
    logic [imvm_pkg::NQ_BITS-1:0]      r_nq;
    logic [imvm_pkg::PROD_BITS-1:0]    r_sq_lo;
    logic [imvm_pkg::PROD_BITS-1:0]    r_sq_hi;
    logic [imvm_pkg::DIVISOR_BITS-1:0] r_ntsq;
    logic [imvm_pkg::S2_BITS-1:0]      r_s2;

    // output register
    logic                              r_out_valid;
    logic [imvm_pkg::KIND_BITS-1:0]    r_out_kind;
    logic [imvm_pkg::MEAN_BITS-1:0]    r_out_mean;
    logic [imvm_pkg::VAR_BITS-1:0]     r_out_var;
    logic [imvm_pkg::IDX_BITS-1:0]     r_out_idx;
    logic                              r_out_done;

    logic                              in_fire;
    logic                              whole;
    logic [imvm_pkg::SPM_BITS-1:0]     spm_eff;
    logic [imvm_pkg::MPB_BITS-1:0]     mpb_eff;
    logic [imvm_pkg::TICK_BITS-1:0]    tpm_eff;
    logic [imvm_pkg::TS_BITS-1:0]      span_from;
    logic [imvm_pkg::TS_BITS-1:0]      span_diff;
    logic [imvm_pkg::DUR_BITS-1:0]     n_dur;
    logic [imvm_pkg::DUR_BITS:0]       part_sum_ext;
    logic [imvm_pkg::DUR_BITS-1:0]     n_part_sum;
    logic [imvm_pkg::DUR_BITS-1:0]     dur_sel;
    logic [imvm_pkg::NQ_BITS-1:0]      var_num;
    logic [imvm_pkg::DIVIDEND_BITS-1:0] mean_dividend;
    logic [imvm_pkg::DIVIDEND_BITS-1:0] var_dividend;
    logic [imvm_pkg::DIVIDEND_BITS-1:0] mean_quot;
    logic [imvm_pkg::DIVIDEND_BITS-1:0] var_quot;
    logic                              mean_busy;
    logic                              var_busy;
    logic [imvm_pkg::MPB_BITS:0]       n_meas_count;
    logic                              batch_last;
    logic                              out_free;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // effective configuration, out-of-range values clamped
    always_comb begin
        whole   = (r_max_part == '0);
        spm_eff = r_spm;
        if (r_spm == '0) begin
            spm_eff = imvm_pkg::SPM_BITS'(1);
        end else if (r_spm > imvm_pkg::SPM_BITS'(imvm_pkg::MAX_SAMPLES)) begin
            spm_eff = imvm_pkg::SPM_BITS'(imvm_pkg::MAX_SAMPLES);
        end
        mpb_eff = (r_mpb == '0) ? imvm_pkg::MPB_BITS'(1) : r_mpb;
        tpm_eff = (r_tpm == '0) ? imvm_pkg::TICK_BITS'(1) : r_tpm;
    end

    // interval since the relevant start, saturated
    always_comb begin
        span_from = (r_ev_act == imvm_pkg::ACT_END_PARTIAL) ? r_part_start : r_sample_start;
        span_diff = r_ev_ts - span_from;
        if (|span_diff[imvm_pkg::TS_BITS-1:imvm_pkg::DUR_BITS]) begin
            n_dur = imvm_pkg::DUR_CAP;
        end else begin
            n_dur = span_diff[imvm_pkg::DUR_BITS-1:0];
        end
        part_sum_ext = {1'b0, r_part_sum} + {1'b0, r_dur};
        n_part_sum   = part_sum_ext[imvm_pkg::DUR_BITS] ? imvm_pkg::DUR_CAP
                                                        : part_sum_ext[imvm_pkg::DUR_BITS-1:0];
        dur_sel      = whole ? r_dur : r_part_sum;
    end

    // variance numerator N*Q - S^2, clamped at zero
    always_comb begin
        if (r_nq >= imvm_pkg::NQ_BITS'(r_s2)) begin
            var_num = r_nq - imvm_pkg::NQ_BITS'(r_s2);
        end else begin
            var_num = '0;
        end
        var_dividend  = {var_num, {imvm_pkg::VAR_FRAC{1'b0}}};
        mean_dividend = imvm_pkg::DIVIDEND_BITS'({r_dur_sum, {imvm_pkg::MEAN_FRAC{1'b0}}});
        n_meas_count  = {1'b0, r_meas_count} + 1'b1;
        batch_last    = (n_meas_count >= {1'b0, mpb_eff});
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm      <= imvm_pkg::SPM_RESET;
            r_mpb      <= imvm_pkg::MPB_RESET;
            r_max_part <= imvm_pkg::PART_RESET;
            r_tpm      <= imvm_pkg::TICK_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                imvm_pkg::CFG_SPM:  r_spm      <= i_cfg_data[imvm_pkg::SPM_BITS-1:0];
                imvm_pkg::CFG_MPB:  r_mpb      <= i_cfg_data[imvm_pkg::MPB_BITS-1:0];
                imvm_pkg::CFG_PART: r_max_part <= i_cfg_data[imvm_pkg::PART_BITS-1:0];
                imvm_pkg::CFG_TICK: r_tpm      <= i_cfg_data[imvm_pkg::TICK_BITS-1:0];
                default:            r_spm      <= r_spm;
            endcase
        end
    end

    // event capture and interval
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ev_act <= imvm_pkg::t_action'(i_in.action);
            r_ev_ts  <= i_in.timestamp;
        end
        if (i_cmd.calc_dur) begin
            r_dur <= n_dur;
        end
        if (i_cmd.acc_sample) begin
            r_sq_dur <= imvm_pkg::SQ_DUR_BITS'(dur_sel) * imvm_pkg::SQ_DUR_BITS'(dur_sel);
        end
    end

    // sample and partial state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sampling     <= 1'b0;
            r_sample_start <= '0;
            r_part_open    <= 1'b0;
            r_part_start   <= '0;
            r_part_count   <= '0;
            r_part_sum     <= '0;
        end else begin
            if (i_cmd.start_sample) begin
                r_sampling     <= 1'b1;
                r_sample_start <= r_ev_ts;
            end
            // a partial still open at the end of a sample is dropped
            if (i_cmd.end_sample) begin
                r_sampling  <= 1'b0;
                r_part_open <= 1'b0;
            end
            if (i_cmd.start_partial) begin
                r_part_open  <= 1'b1;
                r_part_start <= r_ev_ts;
            end
            if (i_cmd.close_partial) begin
                r_part_open <= 1'b0;
            end
            if (i_cmd.acc_partial) begin
                r_part_count <= r_part_count + 1'b1;
                r_part_sum   <= n_part_sum;
            end
            // a new sample, an empty end or a counted sample drops the partials
            if (i_cmd.start_sample || i_cmd.clear_partials || i_cmd.acc_sample) begin
                r_part_open  <= 1'b0;
                r_part_start <= '0;
                r_part_count <= '0;
                r_part_sum   <= '0;
            end
        end
    end

    // running sums and the batch counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= '0;
            r_dur_sum      <= '0;
            r_sq_sum       <= '0;
            r_meas_count   <= '0;
        end else begin
            if (i_cmd.acc_sample) begin
                r_sample_count <= r_sample_count + 1'b1;
                r_dur_sum      <= r_dur_sum + imvm_pkg::SUM_BITS'(dur_sel);
            end
            if (i_cmd.acc_square) begin
                r_sq_sum <= r_sq_sum + imvm_pkg::SQ_SUM_BITS'(r_sq_dur);
            end
            if (i_cmd.emit && (i_cmd.kind == imvm_pkg::KIND_MEAS)) begin
                r_sample_count <= '0;
                r_dur_sum      <= '0;
                r_sq_sum       <= '0;
                r_meas_count   <= batch_last ? '0 : n_meas_count[imvm_pkg::MPB_BITS-1:0];
            end
        end
    end

    // products for the closing step, one multiplier deep per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_nt    <= imvm_pkg::NT_BITS'(r_sample_count) * imvm_pkg::NT_BITS'(tpm_eff);
            r_nq    <= imvm_pkg::NQ_BITS'(r_sample_count) * imvm_pkg::NQ_BITS'(r_sq_sum);
            r_sq_lo <= imvm_pkg::PROD_BITS'(r_dur_sum)
                     * imvm_pkg::PROD_BITS'(r_dur_sum[imvm_pkg::HALF_BITS-1:0]);
        end
        if (i_cmd.mul2) begin
            r_ntsq  <= imvm_pkg::DIVISOR_BITS'(r_nt) * imvm_pkg::DIVISOR_BITS'(r_nt);
            r_sq_hi <= imvm_pkg::PROD_BITS'(r_dur_sum)
                     * imvm_pkg::PROD_BITS'(r_dur_sum[imvm_pkg::SUM_BITS-1:imvm_pkg::HALF_BITS]);
        end
        if (i_cmd.mul3) begin
            r_s2 <= imvm_pkg::S2_BITS'(r_sq_lo)
                  + (imvm_pkg::S2_BITS'(r_sq_hi) << imvm_pkg::HALF_BITS);
        end
    end

    // mean: S * 2^16 / (N*T)
    imvm_div u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mean_dividend),
        .i_divisor  (imvm_pkg::DIVISOR_BITS'(r_nt)),
        .o_busy     (mean_busy),
        .o_quot     (mean_quot)
    );

    // variance: (N*Q - S^2) * 2^8 / (N*T)^2
    imvm_div u_var_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (var_dividend),
        .i_divisor  (r_ntsq),
        .o_busy     (var_busy),
        .o_quot     (var_quot)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.kind;
            if (i_cmd.kind == imvm_pkg::KIND_MEAS) begin
                r_out_mean <= mean_quot[imvm_pkg::MEAN_BITS-1:0];
                r_out_var  <= var_quot[imvm_pkg::VAR_BITS-1:0];
                r_out_idx  <= r_meas_count;
                r_out_done <= batch_last;
            end else begin
                r_out_mean <= '0;
                r_out_var  <= '0;
                r_out_idx  <= '0;
                r_out_done <= 1'b0;
            end
        end
    end

    assign i_in.ready              = i_cmd.in_ready;
    assign o_out.valid             = r_out_valid;
    assign o_out.kind              = r_out_kind;
    assign o_out.mean_ms           = r_out_mean;
    assign o_out.variance_ms2      = r_out_var;
    assign o_out.measurement_index = r_out_idx;
    assign o_out.batch_done        = r_out_done;

    // status to the controller
    always_comb begin
        o_status.in_fire     = in_fire;
        o_status.act         = r_ev_act;
        o_status.sampling    = r_sampling;
        o_status.whole       = whole;
        o_status.part_open   = r_part_open;
        o_status.part_full   = (r_part_count >= r_max_part);
        o_status.no_partials = (r_part_count == '0);
        o_status.meas_ready  = (r_sample_count >= spm_eff);
        o_status.div_busy    = mean_busy || var_busy;
        o_status.out_free    = out_free;
    end

`ifndef ASSERT_OFF
    // no new event while a closing division runs
    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> !(mean_busy || var_busy))
        else $error("event accepted during division");

    // both dividers run in lockstep
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mean_busy == var_busy)
        else $error("dividers out of step");

    // an open partial only exists inside a sample
    a_partial_in_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_part_open |-> r_sampling)
        else $error("partial open outside a sample");

    // sample count stays within the clamp
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sample_count <= imvm_pkg::SPM_BITS'(imvm_pkg::MAX_SAMPLES))
        else $error("sample count beyond limit");

    // a measurement transfer clears the sums
    a_meas_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (i_cmd.kind == imvm_pkg::KIND_MEAS)) |=>
            (r_sample_count == '0) && (r_dur_sum == '0))
        else $error("sums not cleared after measurement");
`endif

endmodule

`default_nettype wire

FILE: design/interval_mean_variance_monitor.sv
`default_nettype none

// Interval mean and variance monitor. Each input transfer is one timestamped
// event (start sample, start partial, end partial, end sample). Durations are
// taken modulo 2^32 ticks and saturate at 2^24-1; with max_partials nonzero a
// sample's duration is the sum of its closed partial intervals. After
// samples_per_measurement counted samples one result gives the mean in ms
// (Q24.16) and the population variance in ms^2 (Q48.8), both truncated, plus
// the index within the batch and a batch-done flag. Results of kind 1 (end of
// a sample with no partials) and kind 2 (partial over the limit) carry zeros.
// Each event is captured, then evaluated; a closing partial is accumulated, a
// kind 1 or kind 2 result emitted, a counted sample added to sum and square;
// a completed measurement is then multiplied out and divided in two 77-step
// restoring dividers side by side. A result waits in an output register, and
// the next event is accepted while it waits; a new result stalls until the
// previous one has been taken. Configuration is to be written only while no
// event is in flight; the block itself does not enforce this.
module interval_mean_variance_monitor (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [imvm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [imvm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    imvm_in_if.sink                              i_in,
    imvm_out_if.source                           o_out
);

    imvm_pkg::t_cmd    cmd;
    imvm_pkg::t_status status;

    // sequencing
    imvm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // state, sums, multipliers and dividers
    imvm_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 6;
    localparam int DRAIN_CYCLES = 100;
    localparam int DRAIN_LIMIT = 20000;

    // one result as the block reports it
    typedef struct packed {
        imvm_pkg::t_kind                kind;
        logic [imvm_pkg::MEAN_BITS-1:0] mean_ms;
        logic [imvm_pkg::VAR_BITS-1:0]  variance_ms2;
        logic [imvm_pkg::IDX_BITS-1:0]  meas_idx;
        logic                           batch_done;
    } t_stats;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [imvm_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [imvm_pkg::CFG_DATA_BITS-1:0] i_cfg_data;

    imvm_in_if  in_if ();
    imvm_out_if out_if ();

    interval_mean_variance_monitor DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // shadow copy of the registers
    logic [imvm_pkg::SPM_BITS-1:0]  cfg_spm;
    logic [imvm_pkg::MPB_BITS-1:0]  cfg_mpb;
    logic [imvm_pkg::PART_BITS-1:0] cfg_parts;
    logic [imvm_pkg::TICK_BITS-1:0] cfg_ticks;

    // shadow copy of the interval and sum state
    logic                             sampling;
    logic [imvm_pkg::TS_BITS-1:0]     sample_t0;
    logic                             part_open;
    logic [imvm_pkg::TS_BITS-1:0]     part_t0;
    logic [imvm_pkg::PART_BITS-1:0]   part_cnt;
    logic [imvm_pkg::DUR_BITS-1:0]    part_sum;
    logic [imvm_pkg::SPM_BITS-1:0]    samp_cnt;
    logic [imvm_pkg::SUM_BITS-1:0]    dur_sum;
    logic [imvm_pkg::SQ_SUM_BITS-1:0] sq_sum;
    logic [imvm_pkg::IDX_BITS-1:0]    meas_cnt;

    t_stats expected_stats[$];

    bit          gaps_on;
    logic [imvm_pkg::TS_BITS-1:0] ts_now;
    int unsigned sent_items;
    int unsigned cfg_writes;
    int unsigned results_seen;
    int unsigned meas_seen;
    int unsigned batches_seen;
    int unsigned fail_count;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // receiver stalls at random unless the quiet stretch is running
    always @(posedge i_clk) begin
        out_if.ready <= !gaps_on || ($urandom_range(99) >= 35);
    end

    // span between two timestamps, modulo 2^32, saturated
    function automatic logic [imvm_pkg::DUR_BITS-1:0] clipped_span(
            input logic [imvm_pkg::TS_BITS-1:0] from,
            input logic [imvm_pkg::TS_BITS-1:0] upto);
        logic [imvm_pkg::TS_BITS-1:0] d;
        d = upto - from;
        return (d > imvm_pkg::TS_BITS'(imvm_pkg::DUR_CAP)) ? imvm_pkg::DUR_CAP
                                                           : d[imvm_pkg::DUR_BITS-1:0];
    endfunction

    function automatic void clear_partials();
        part_open = 1'b0;
        part_t0   = '0;
        part_cnt  = '0;
        part_sum  = '0;
    endfunction

    // interval statistics for one event; returns 1 when a result is due
    function automatic bit predict_interval_stats(input imvm_pkg::t_action act,
                                                  input logic [imvm_pkg::TS_BITS-1:0] ts,
                                                  output t_stats res);
        logic [imvm_pkg::DUR_BITS:0]   psum;
        logic [imvm_pkg::DUR_BITS-1:0] dur;
        logic [imvm_pkg::SPM_BITS-1:0] n_limit;
        logic [63:0]                   nt;
        logic [127:0]                  spread;
        logic [127:0]                  sum_sq;
        logic [imvm_pkg::IDX_BITS:0]   next_idx;
        logic [imvm_pkg::IDX_BITS:0]   batch_len;
        bit                            whole;
        res = '0;
        whole = (cfg_parts == 0);
        case (act)
            imvm_pkg::ACT_START_SAMPLE: begin
                sampling  = 1'b1;
                sample_t0 = ts;
                clear_partials();
                return 1'b0;
            end
            imvm_pkg::ACT_START_PARTIAL: begin
                if (sampling && !whole) begin
                    part_open = 1'b1;
                    part_t0   = ts;
                end
                return 1'b0;
            end
            imvm_pkg::ACT_END_PARTIAL: begin
                if (!sampling || whole || !part_open) return 1'b0;
                part_open = 1'b0;
                if (part_cnt >= cfg_parts) begin
                    res.kind = imvm_pkg::KIND_TOO_MANY;
                    return 1'b1;
                end
                part_cnt = part_cnt + 1'b1;
                psum = {1'b0, part_sum} + {1'b0, clipped_span(part_t0, ts)};
                part_sum = psum[imvm_pkg::DUR_BITS] ? imvm_pkg::DUR_CAP
                                                    : psum[imvm_pkg::DUR_BITS-1:0];
                return 1'b0;
            end
            default: begin
            end
        endcase

        // end of sample
        if (!sampling) return 1'b0;
        sampling = 1'b0;
        if (whole) begin
            dur = clipped_span(sample_t0, ts);
        end else if (part_cnt == 0) begin
            clear_partials();
            res.kind = imvm_pkg::KIND_NO_PARTIALS;
            return 1'b1;
        end else begin
            dur = part_sum;
        end
        clear_partials();

        samp_cnt = samp_cnt + 1'b1;
        dur_sum  = dur_sum + imvm_pkg::SUM_BITS'(dur);
        sq_sum   = sq_sum + imvm_pkg::SQ_SUM_BITS'(dur) * imvm_pkg::SQ_SUM_BITS'(dur);

        n_limit = (cfg_spm == 0) ? imvm_pkg::SPM_BITS'(1) :
                  (cfg_spm > imvm_pkg::MAX_SAMPLES) ? imvm_pkg::SPM_BITS'(imvm_pkg::MAX_SAMPLES)
                                                    : cfg_spm;
        if (samp_cnt < n_limit) return 1'b0;

        // mean and population variance over the samples actually taken
        nt = 64'(samp_cnt) * 64'((cfg_ticks == 0) ? imvm_pkg::TICK_BITS'(1) : cfg_ticks);
        res.kind    = imvm_pkg::KIND_MEAS;
        res.mean_ms = imvm_pkg::MEAN_BITS'((64'(dur_sum) << imvm_pkg::MEAN_FRAC) / nt);
        spread = 128'(samp_cnt) * 128'(sq_sum);
        sum_sq = 128'(dur_sum) * 128'(dur_sum);
        spread = (spread < sum_sq) ? 128'd0 : spread - sum_sq;
        res.variance_ms2 = imvm_pkg::VAR_BITS'((spread << imvm_pkg::VAR_FRAC)
                                               / (128'(nt) * 128'(nt)));

        // position in the batch
        next_idx  = {1'b0, meas_cnt} + 1'b1;
        batch_len = (cfg_mpb == 0) ? (imvm_pkg::IDX_BITS+1)'(1) : {1'b0, cfg_mpb};
        res.meas_idx = meas_cnt;
        if (next_idx >= batch_len) begin
            res.batch_done = 1'b1;
            meas_cnt = '0;
        end else begin
            meas_cnt = next_idx[imvm_pkg::IDX_BITS-1:0];
        end

        samp_cnt = '0;
        dur_sum  = '0;
        sq_sum   = '0;
        return 1'b1;
    endfunction

    task automatic report_fail(input string what, input t_stats want, input t_stats got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t %s: expected kind %0d mean %h var %h idx %0d done %0b",
                     $realtime, what, want.kind, want.mean_ms, want.variance_ms2,
                     want.meas_idx, want.batch_done);
            $display("    got kind %0d mean %h var %h idx %0d done %0b",
                     got.kind, got.mean_ms, got.variance_ms2, got.meas_idx, got.batch_done);
        end
    endtask

    // watch every transfer: results first, then register writes, then events
    always @(posedge i_clk) begin : watch
        t_stats got;
        t_stats want;
        t_stats res;
        if (!i_rst_n) begin
            cfg_spm   = imvm_pkg::SPM_RESET;
            cfg_mpb   = imvm_pkg::MPB_RESET;
            cfg_parts = imvm_pkg::PART_RESET;
            cfg_ticks = imvm_pkg::TICK_RESET;
            sampling  = 1'b0;
            sample_t0 = '0;
            clear_partials();
            samp_cnt  = '0;
            dur_sum   = '0;
            sq_sum    = '0;
            meas_cnt  = '0;
        end else begin
            // compare each result with the oldest expectation
            if (out_if.valid && out_if.ready) begin
                got.kind         = imvm_pkg::t_kind'(out_if.kind);
                got.mean_ms      = out_if.mean_ms;
                got.variance_ms2 = out_if.variance_ms2;
                got.meas_idx     = out_if.measurement_index;
                got.batch_done   = out_if.batch_done;
                results_seen++;
                if (got.kind == imvm_pkg::KIND_MEAS) meas_seen++;
                if (got.batch_done) batches_seen++;
                if (expected_stats.size() == 0) begin
                    report_fail("unexpected result", '0, got);
                end else begin
                    want = expected_stats.pop_front();
                    if (got.kind !== want.kind || got.mean_ms !== want.mean_ms ||
                        got.variance_ms2 !== want.variance_ms2 ||
                        got.meas_idx !== want.meas_idx ||
                        got.batch_done !== want.batch_done) begin
                        report_fail("result mismatch", want, got);
                    end
                end
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    imvm_pkg::CFG_SPM:  cfg_spm   = i_cfg_data[imvm_pkg::SPM_BITS-1:0];
                    imvm_pkg::CFG_MPB:  cfg_mpb   = i_cfg_data[imvm_pkg::MPB_BITS-1:0];
                    imvm_pkg::CFG_PART: cfg_parts = i_cfg_data[imvm_pkg::PART_BITS-1:0];
                    imvm_pkg::CFG_TICK: cfg_ticks = i_cfg_data[imvm_pkg::TICK_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            // events
            if (in_if.valid && in_if.ready) begin
                if (predict_interval_stats(imvm_pkg::t_action'(in_if.action),
                                           in_if.timestamp, res))
                    expected_stats = {expected_stats, res};
            end
        end
    end

    // one event transfer; valid stays high for a following event
    task automatic send_event(input imvm_pkg::t_action act,
                              input logic [imvm_pkg::TS_BITS-1:0] ts);
        while (gaps_on && $urandom_range(99) < 35) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.action    <= act;
        in_if.timestamp <= ts;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic send_at(input imvm_pkg::t_action act,
                           input logic [imvm_pkg::TS_BITS-1:0] gap);
        ts_now = ts_now + gap;
        send_event(act, ts_now);
    endtask

    // mostly short spans, some near the cap, some across the whole range
    function automatic logic [imvm_pkg::TS_BITS-1:0] pick_span();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 65) return $urandom_range(4000);
        if (sel < 80) return $urandom_range(32'h00FF_FFFF);
        if (sel < 88) return 32'h00FF_FFFF + $urandom_range(2) - 1;
        return $urandom;
    endfunction

    // drop valid, wait for all results, then let the block settle
    task automatic wait_drained();
        int unsigned waited;
        waited = 0;
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_stats.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [imvm_pkg::CFG_IDX_BITS-1:0] idx,
                             input int unsigned value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= imvm_pkg::CFG_DATA_BITS'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
    endtask

    task automatic write_all(input int unsigned spm, input int unsigned mpb,
                             input int unsigned parts, input int unsigned ticks);
        write_reg(imvm_pkg::CFG_SPM, spm);
        write_reg(imvm_pkg::CFG_MPB, mpb);
        write_reg(imvm_pkg::CFG_PART, parts);
        write_reg(imvm_pkg::CFG_TICK, ticks);
    endtask

    // whole-interval sample with the odd restart or stray partial event
    task automatic random_whole_sample();
        send_at(imvm_pkg::ACT_START_SAMPLE, pick_span());
        if ($urandom_range(9) == 0) send_at(imvm_pkg::ACT_START_SAMPLE, pick_span());
        if ($urandom_range(9) == 0)
            send_at($urandom_range(1) ? imvm_pkg::ACT_START_PARTIAL
                                      : imvm_pkg::ACT_END_PARTIAL, pick_span());
        send_at(imvm_pkg::ACT_END_SAMPLE, pick_span());
    endtask

    // partial-mode sample, sometimes over the limit or with a partial left open
    task automatic random_partial_sample(input int unsigned lim);
        int unsigned cnt;
        cnt = $urandom_range(((lim < 5) ? lim : 5) + 1);
        send_at(imvm_pkg::ACT_START_SAMPLE, pick_span());
        repeat (cnt) begin
            send_at(imvm_pkg::ACT_START_PARTIAL, $urandom_range(500));
            if ($urandom_range(9) == 0) send_at(imvm_pkg::ACT_START_PARTIAL, pick_span());
            send_at(imvm_pkg::ACT_END_PARTIAL, pick_span());
            if ($urandom_range(15) == 0) send_at(imvm_pkg::ACT_END_PARTIAL, pick_span());
        end
        if ($urandom_range(7) == 0) send_at(imvm_pkg::ACT_START_PARTIAL, pick_span());
        if ($urandom_range(19) == 0) send_at(imvm_pkg::ACT_START_SAMPLE, pick_span());
        send_at(imvm_pkg::ACT_END_SAMPLE, pick_span());
    endtask

    // whole-interval corner spans
    task automatic test_directed_whole();
        write_all(2, 3, 0, 1);
        // stray events with no sample open
        send_event(imvm_pkg::ACT_END_SAMPLE, 32'h0000_0100);
        send_event(imvm_pkg::ACT_START_PARTIAL, 32'h0000_0200);
        send_event(imvm_pkg::ACT_END_PARTIAL, 32'h0000_0300);
        // span across the timestamp wrap
        send_event(imvm_pkg::ACT_START_SAMPLE, 32'hFFFF_FFF0);
        send_event(imvm_pkg::ACT_END_SAMPLE, 32'h0000_0010);
        // restart, then the longest span saturates
        send_event(imvm_pkg::ACT_START_SAMPLE, 32'h0000_0000);
        send_event(imvm_pkg::ACT_START_SAMPLE, 32'h0000_0005);
        send_event(imvm_pkg::ACT_END_SAMPLE, 32'h0000_0004);
        // zero span, then one tick past the cap
        send_event(imvm_pkg::ACT_START_SAMPLE, 32'h8000_0000);
        send_event(imvm_pkg::ACT_END_SAMPLE, 32'h8000_0000);
        send_event(imvm_pkg::ACT_START_SAMPLE, 32'h1234_5678);
        send_event(imvm_pkg::ACT_END_SAMPLE, 32'h1334_5678);
        wait_drained();
    endtask

    // partial-mode corner cases
    task automatic test_directed_partial();
        // sample opened in whole mode, then the mode changes under it
        send_event(imvm_pkg::ACT_START_SAMPLE, 32'h0000_1000);
        wait_drained();
        write_all(1, 0, 1, 0);
        write_reg(imvm_pkg::CFG_PART, 2);
        send_event(imvm_pkg::ACT_END_PARTIAL, 32'h0000_1100);
        send_event(imvm_pkg::ACT_START_PARTIAL, 32'h0000_1200);
        send_event(imvm_pkg::ACT_START_PARTIAL, 32'h0000_1300);
        send_event(imvm_pkg::ACT_END_PARTIAL, 32'h0000_1400);
        // capped partial makes the sum saturate
        send_event(imvm_pkg::ACT_START_PARTIAL, 32'h0000_2000);
        send_event(imvm_pkg::ACT_END_PARTIAL, 32'h0100_2000);
        // one partial over the limit
        send_event(imvm_pkg::ACT_START_PARTIAL, 32'h0200_0000);
        send_event(imvm_pkg::ACT_END_PARTIAL, 32'h0200_0010);
        send_event(imvm_pkg::ACT_END_SAMPLE, 32'h0300_0000);
        // only an open partial at the end of the sample
        send_event(imvm_pkg::ACT_START_SAMPLE, 32'hFFFF_FFFF);
        send_event(imvm_pkg::ACT_START_PARTIAL, 32'h0000_0001);
        send_event(imvm_pkg::ACT_END_SAMPLE, 32'h0000_0002);
        // partial events with no sample open
        send_event(imvm_pkg::ACT_START_PARTIAL, 32'h0000_0003);
        send_event(imvm_pkg::ACT_END_PARTIAL, 32'h0000_0004);
        wait_drained();
    endtask

    // sample limit lowered while a measurement is part way through
    task automatic test_limit_lowered();
        write_all(2047, 2, 0, 1000);
        repeat (3) random_whole_sample();
        wait_drained();
        write_reg(imvm_pkg::CFG_SPM, 2);
        random_whole_sample();
        wait_drained();
    endtask

    // back-to-back samples with no idling on either side
    task automatic test_no_idling();
        int unsigned k;
        gaps_on = 1'b0;
        write_all(5, 3, 0, 20'hFFFFF);
        for (k = 0; k < 25; k++) random_whole_sample();
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // random samples over a sweep of register settings
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned spm;
        int unsigned mpb;
        int unsigned parts;
        int unsigned ticks;
        int unsigned first;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    spm = $urandom_range(4, 1);  mpb = $urandom_range(4, 1);
                    parts = 0;                   ticks = $urandom_range(1000000, 1);
                end
                1: begin
                    spm = $urandom_range(6, 1);  mpb = 65535;
                    parts = $urandom_range(3, 1); ticks = $urandom_range(20'hFFFFF);
                end
                2: begin
                    spm = 1;  mpb = 1;  parts = 255;  ticks = 20'hFFFFF;
                end
                3: begin
                    spm = $urandom_range(8, 1);  mpb = $urandom_range(3);
                    parts = $urandom_range(4, 1); ticks = 1;
                end
                4: begin
                    spm = $urandom_range(5, 2);  mpb = $urandom_range(7, 1);
                    parts = 0;                   ticks = $urandom_range(5000, 1);
                end
                default: begin
                    spm = 0;  mpb = $urandom_range(2);
                    parts = $urandom_range(2);  ticks = 0;
                end
            endcase
            write_all(spm, mpb, parts, ticks);
            first = sent_items;
            while (sent_items - first < 50) begin
                if ($urandom_range(19) == 0) begin
                    // stray event at an arbitrary timestamp
                    ts_now = $urandom;
                    send_event(imvm_pkg::t_action'(imvm_pkg::ACTION_BITS'($urandom_range(3))),
                               ts_now);
                end else if (parts == 0) begin
                    random_whole_sample();
                end else begin
                    random_partial_sample(parts);
                end
            end
            wait_drained();
        end
    endtask

    // run limit
    initial begin : watchdog
        #15_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : run
        gaps_on      = 1'b1;
        ts_now       = $urandom;
        sent_items   = 0;
        cfg_writes   = 0;
        results_seen = 0;
        meas_seen    = 0;
        batches_seen = 0;
        fail_count   = 0;
        in_if.valid     <= 1'b0;
        in_if.action    <= '0;
        in_if.timestamp <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= '0;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        test_directed_whole();
        test_directed_partial();
        test_limit_lowered();
        test_no_idling();
        test_random_traffic();

        if (expected_stats.size() != 0) begin
            $display("%0d expected results never arrived", expected_stats.size());
            fail_count += expected_stats.size();
        end
        $display("%0d events, %0d register writes, %0d results (%0d measurements, %0d batch ends)",
                 sent_items, cfg_writes, results_seen, meas_seen, batches_seen);
        $display("swept whole and partial modes, sample limits 0..2047, batches 0..65535, ticks 0..max");
        if (fail_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
